### src/c3cf_pkg.sv
package c3cf_pkg;

	localparam int MAX_LINE_DEF  = 2048;
	localparam int COEF_BITS_DEF = 8;

	localparam int PIXEL_W   = 8;
	localparam int KROW_W    = 24;
	localparam int FWIDTH_W  = 12;
	localparam int FHEIGHT_W = 16;
	localparam int APB_AW    = 5;
	localparam int APB_DW    = 32;

	// smallest usable frame dimension and top of the output range
	localparam int MIN_DIM = 3;
	localparam int PIX_MAX = 255;

	localparam logic [FWIDTH_W-1:0]  FWIDTH_RST  = FWIDTH_W'(640);
	localparam logic [FHEIGHT_W-1:0] FHEIGHT_RST = FHEIGHT_W'(480);

	typedef enum logic [2:0] {
		REG_KERNEL_TOP = 3'd0,
		REG_KERNEL_MID = 3'd1,
		REG_KERNEL_BOT = 3'd2,
		REG_FRAME_W    = 3'd3,
		REG_FRAME_H    = 3'd4
	} reg_idx_t;

endpackage

### src/conv3x3_clamped_filter.sv
// 3x3 convolution over a raster-order 8-bit grayscale stream, one pixel per clock.
// A pixel word accepted on the slave side yields at most one output word: the clamped
// (0..255) kernel sum for the centre one line up and one column left, produced only
// for interior positions; border positions give no output. tlast marks the last
// interior result of the frame. The block sustains one pixel per clock unless the
// output stalls, set by the line store (MAX_LINE x 16, one read and one write per
// cycle). The line store is not cleared after reset; an entry that feeds an output
// is written before it is read if the frame geometry is only changed between frames.
// Kernel rows, frame width and frame height sit behind the APB port at byte addresses
// 0x00, 0x04, 0x08, 0x0C and 0x10; write them only while idle.
module conv3x3_clamped_filter #(
	parameter int MAX_LINE  = c3cf_pkg::MAX_LINE_DEF,
	parameter int COEF_BITS = c3cf_pkg::COEF_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [c3cf_pkg::PIXEL_W-1:0]  s_tdata,   // [7:0] pixel
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [c3cf_pkg::PIXEL_W-1:0]  m_tdata,   // [7:0] filtered
	output logic                          m_tlast,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [c3cf_pkg::APB_AW-1:0]   paddr,
	input  logic [c3cf_pkg::APB_DW-1:0]   pwdata,
	output logic [c3cf_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);

	localparam int PW     = c3cf_pkg::PIXEL_W;
	localparam int COL_W  = $clog2(MAX_LINE);
	localparam int EW     = (COL_W + 1 > c3cf_pkg::FWIDTH_W) ? COL_W + 1 : c3cf_pkg::FWIDTH_W;
	localparam int HW     = c3cf_pkg::FHEIGHT_W;
	localparam int KW     = (3 * COEF_BITS > c3cf_pkg::KROW_W) ? 3 * COEF_BITS
	                                                           : c3cf_pkg::KROW_W;
	localparam int PROD_W = COEF_BITS + PW + 1;
	localparam int SUM_W  = PROD_W + 4;

	// configuration registers
	logic [c3cf_pkg::KROW_W-1:0]    krow_top_q, krow_mid_q, krow_bot_q;
	logic [c3cf_pkg::FWIDTH_W-1:0]  fwidth_q;
	logic [c3cf_pkg::FHEIGHT_W-1:0] fheight_q;
	c3cf_pkg::reg_idx_t             reg_idx;
	logic                           cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = c3cf_pkg::reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			krow_top_q <= '0;
			krow_mid_q <= '0;
			krow_bot_q <= '0;
			fwidth_q   <= c3cf_pkg::FWIDTH_RST;
			fheight_q  <= c3cf_pkg::FHEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				c3cf_pkg::REG_KERNEL_TOP: krow_top_q <= pwdata[c3cf_pkg::KROW_W-1:0];
				c3cf_pkg::REG_KERNEL_MID: krow_mid_q <= pwdata[c3cf_pkg::KROW_W-1:0];
				c3cf_pkg::REG_KERNEL_BOT: krow_bot_q <= pwdata[c3cf_pkg::KROW_W-1:0];
				c3cf_pkg::REG_FRAME_W:    fwidth_q   <= pwdata[c3cf_pkg::FWIDTH_W-1:0];
				c3cf_pkg::REG_FRAME_H:    fheight_q  <= pwdata[c3cf_pkg::FHEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			c3cf_pkg::REG_KERNEL_TOP: prdata = c3cf_pkg::APB_DW'(krow_top_q);
			c3cf_pkg::REG_KERNEL_MID: prdata = c3cf_pkg::APB_DW'(krow_mid_q);
			c3cf_pkg::REG_KERNEL_BOT: prdata = c3cf_pkg::APB_DW'(krow_bot_q);
			c3cf_pkg::REG_FRAME_W:    prdata = c3cf_pkg::APB_DW'(fwidth_q);
			c3cf_pkg::REG_FRAME_H:    prdata = c3cf_pkg::APB_DW'(fheight_q);
			default:                  prdata = '0;
		endcase
	end

	// pipeline control: each stage moves when the next one is empty or moving
	logic v1_s1, v2_s2, out_valid_q;
	logic en1, en2, en3, accept, adv1;

	assign en3      = !out_valid_q || m_tready;
	assign en2      = !v2_s2 || en3;
	assign en1      = !v1_s1 || en2;
	assign s_tready = en1;
	assign accept   = s_tvalid && s_tready;
	assign adv1     = v1_s1 && en2;

	// position counters and frame geometry
	logic [COL_W-1:0] col_q;
	logic [HW-1:0]    row_q;
	logic [EW-1:0]    fw_ext, eff_w;
	logic [HW-1:0]    eff_h;
	logic             last_col, last_row, emit;

	always_comb begin
		fw_ext = EW'(fwidth_q);
		priority if (fw_ext < EW'(c3cf_pkg::MIN_DIM)) eff_w = EW'(c3cf_pkg::MIN_DIM);
		else if (fw_ext > EW'(MAX_LINE))             eff_w = EW'(MAX_LINE);
		else                                          eff_w = fw_ext;
		eff_h = (fheight_q < HW'(c3cf_pkg::MIN_DIM)) ? HW'(c3cf_pkg::MIN_DIM) : fheight_q;
	end

	assign last_col = (EW'(col_q) + EW'(1)) >= eff_w;
	assign last_row = ((HW + 1)'(row_q) + (HW + 1)'(1)) >= (HW + 1)'(eff_h);
	assign emit     = (row_q >= HW'(2)) && (col_q >= COL_W'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + HW'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// line store: low byte one line up, high byte two lines up
	logic [2*PW-1:0]  line_mem [MAX_LINE];
	logic [2*PW-1:0]  rd_s1;
	logic [PW-1:0]    px_s1;
	logic [COL_W-1:0] col_s1;
	logic             emit_s1, last_s1;

	always_ff @(posedge clk) begin
		if (accept)
			rd_s1 <= line_mem[col_q];
		if (adv1)
			line_mem[col_s1] <= {rd_s1[PW-1:0], px_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (en1) begin
			v1_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= s_tdata;
			col_s1  <= col_q;
			emit_s1 <= emit;
			last_s1 <= last_col && last_row;
		end
	end

	// window: entries 0..2 column c-1 (top, mid, bot), 3..5 column c-2
	logic [PW-1:0] win_q [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++)
				win_q[i] <= '0;
		end else if (adv1) begin
			win_q[3] <= win_q[0];
			win_q[4] <= win_q[1];
			win_q[5] <= win_q[2];
			win_q[0] <= rd_s1[2*PW-1:PW];
			win_q[1] <= rd_s1[PW-1:0];
			win_q[2] <= px_s1;
		end
	end

	// products, row major, left to right
	logic [KW-1:0]               krow [3];
	logic [COEF_BITS-1:0]        coef [9];
	logic [PW-1:0]               tap  [9];
	logic signed [PROD_W-1:0]    prod [9];
	logic signed [PROD_W-1:0]    prod_s2 [9];
	logic                        emit_s2, last_s2;

	always_comb begin
		krow[0] = KW'(krow_top_q);
		krow[1] = KW'(krow_mid_q);
		krow[2] = KW'(krow_bot_q);
		for (int r = 0; r < 3; r++)
			for (int k = 0; k < 3; k++)
				coef[3*r+k] = krow[r][k*COEF_BITS +: COEF_BITS];
		tap[0] = win_q[3];
		tap[1] = win_q[0];
		tap[2] = rd_s1[2*PW-1:PW];
		tap[3] = win_q[4];
		tap[4] = win_q[1];
		tap[5] = rd_s1[PW-1:0];
		tap[6] = win_q[5];
		tap[7] = win_q[2];
		tap[8] = px_s1;
		for (int i = 0; i < 9; i++)
			prod[i] = PROD_W'($signed(coef[i])) * PROD_W'($signed({1'b0, tap[i]}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else if (en2) begin
			v2_s2 <= v1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			prod_s2 <= prod;
			emit_s2 <= emit_s1;
			last_s2 <= last_s1;
		end
	end

	// sum and clamp into the output register
	logic signed [SUM_W-1:0] sum;
	logic [PW-1:0]           clamped;
	logic [PW-1:0]           out_data_q;
	logic                    out_last_q;
	logic                    load_out;

	always_comb begin
		sum = '0;
		for (int i = 0; i < 9; i++)
			sum = sum + SUM_W'(prod_s2[i]);
		priority if (sum < 0)                             clamped = '0;
		else if (sum > SUM_W'(c3cf_pkg::PIX_MAX))        clamped = PW'(c3cf_pkg::PIX_MAX);
		else                                              clamped = sum[PW-1:0];
	end

	assign load_out = v2_s2 && emit_s2 && en3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en3) begin
			out_valid_q <= v2_s2 && emit_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= clamped;
			out_last_q <= last_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// read and write of the line store never hit the same column in one cycle
	a_mem_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		accept && adv1 |-> col_q != col_s1)
		else $error("line store read and write collide");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < MAX_LINE)
		else $error("column counter out of range");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v1_s1 && !en2 |=> v1_s1 && $stable(col_s1) && $stable(rd_s1))
		else $error("stage 1 lost while stalled");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(v2_s2 && emit_s2))
		else $error("output word without an interior position");

endmodule

### sim/testbench.sv
module testbench;
	import c3cf_pkg::*;

	localparam int LINE_DEPTH    = MAX_LINE_DEF;
	localparam int CW            = COEF_BITS_DEF;
	localparam int FLUSH_CYCLES  = 8;
	localparam int RANDOM_PIXELS = 1250;
	localparam int NUM_REGS      = 5;

	typedef struct packed {
		logic [PIXEL_W-1:0] filtered;
		logic               frame_end;
	} filt_word_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [PIXEL_W-1:0]  s_tdata  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [PIXEL_W-1:0]  m_tdata;
	logic                m_tlast;
	logic                psel     = 1'b0;
	logic                penable  = 1'b0;
	logic                pwrite   = 1'b0;
	logic [APB_AW-1:0]   paddr    = '0;
	logic [APB_DW-1:0]   pwdata   = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	conv3x3_clamped_filter uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// mirror of the block: registers, line history, window columns, raster position
	logic [APB_DW-1:0]  cfg_regs [NUM_REGS] = '{0, 0, 0, FWIDTH_RST, FHEIGHT_RST};
	logic [15:0]        line_hist [LINE_DEPTH];
	logic [PIXEL_W-1:0] col_left [3] = '{default: '0};
	logic [PIXEL_W-1:0] col_mid [3]  = '{default: '0};
	int                 col_pos = 0;
	int                 row_pos = 0;
	// count of line store columns written at least once
	int                 cols_written = 0;

	logic [PIXEL_W-1:0] pixel_queue [$];
	filt_word_t         expected_words [$];
	int                 mismatches = 0;
	bit                 gaps_on = 1'b0;
	int                 feed_wait;
	int                 out_stall;

	function automatic int active_width();
		if (cfg_regs[REG_FRAME_W] < MIN_DIM) return MIN_DIM;
		if (cfg_regs[REG_FRAME_W] > LINE_DEPTH) return LINE_DEPTH;
		return cfg_regs[REG_FRAME_W];
	endfunction

	function automatic int active_height();
		if (cfg_regs[REG_FRAME_H] < MIN_DIM) return MIN_DIM;
		return cfg_regs[REG_FRAME_H];
	endfunction

	function automatic void convolve_pixel(input logic [PIXEL_W-1:0] px);
		int                   w, h, c, acc;
		logic [PIXEL_W-1:0]   above1, above2;
		logic [PIXEL_W-1:0]   nb [3][3];
		logic signed [CW-1:0] k;
		logic                 last_col, last_row;
		filt_word_t           word;
		w = active_width();
		h = active_height();
		c = (col_pos >= LINE_DEPTH) ? LINE_DEPTH - 1 : col_pos;
		above1 = line_hist[c][7:0];
		above2 = line_hist[c][15:8];
		last_col = (c + 1 >= w);
		last_row = (row_pos + 1 >= h);
		if (row_pos >= 2 && c >= 2) begin
			// kernel row i pairs with left, center and incoming column at height i
			for (int i = 0; i < 3; i++) begin
				nb[i][0] = col_left[i];
				nb[i][1] = col_mid[i];
			end
			nb[0][2] = above2;
			nb[1][2] = above1;
			nb[2][2] = px;
			acc = 0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					k = cfg_regs[i][j*CW +: CW];
					acc += k * int'(nb[i][j]);
				end
			end
			if (acc < 0) acc = 0;
			else if (acc > PIX_MAX) acc = PIX_MAX;
			word.filtered = PIXEL_W'(acc);
			word.frame_end = last_col && last_row;
			expected_words.push_back(word);
		end
		line_hist[c] = {above1, px};
		if (c + 1 > cols_written) cols_written = c + 1;
		col_left = col_mid;
		col_mid[0] = above2;
		col_mid[1] = above1;
		col_mid[2] = px;
		if (last_col) begin
			col_pos = 0;
			row_pos = last_row ? 0 : row_pos + 1;
		end else begin
			col_pos = c + 1;
		end
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int draw_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) return 0;
		if (pick < 90) return $urandom_range(1, 3);
		if (pick < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [KROW_W-1:0] pack_row(input int left, input int centre, input int right);
		return {CW'(right), CW'(centre), CW'(left)};
	endfunction

	always @(posedge clk or negedge arst_n) begin : feeder
		logic presenting;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			feed_wait = 0;
		end else begin
			presenting = s_tvalid;
			if (s_tvalid && s_tready) begin
				convolve_pixel(s_tdata);
				presenting = 1'b0;
			end
			if (!presenting) begin
				if (feed_wait > 0) begin
					feed_wait--;
				end else if (pixel_queue.size() != 0) begin
					s_tdata <= pixel_queue.pop_front();
					presenting = 1'b1;
					feed_wait = gaps_on ? draw_gap() : 0;
				end
			end
			s_tvalid <= presenting;
		end
	end

	always @(posedge clk or negedge arst_n) begin : out_mon
		filt_word_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			out_stall = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					$error("output word with none expected: filtered %0d, tlast %0b",
						m_tdata, m_tlast);
					mismatches++;
				end else begin
					want = expected_words.pop_front();
					if (m_tdata !== want.filtered) begin
						$error("filtered: expected %0d, got %0d", want.filtered, m_tdata);
						mismatches++;
					end
					if (m_tlast !== want.frame_end) begin
						$error("frame_end: expected %0b, got %0b", want.frame_end, m_tlast);
						mismatches++;
					end
				end
			end
			if (out_stall > 0) begin
				out_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				out_stall = gaps_on ? draw_gap() : 0;
			end
		end
	end

	task automatic reg_readback(input reg_idx_t idx);
		logic [APB_DW-1:0] got;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		got = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== cfg_regs[idx]) begin
			$error("register %0d: expected %0h, got %0h", idx, cfg_regs[idx], got);
			mismatches++;
		end
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [APB_DW-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		cfg_regs[idx] = val;
		reg_readback(idx);
	endtask

	task automatic write_kernel(input logic [KROW_W-1:0] top, input logic [KROW_W-1:0] mid,
		input logic [KROW_W-1:0] bot);
		reg_write(REG_KERNEL_TOP, top);
		reg_write(REG_KERNEL_MID, mid);
		reg_write(REG_KERNEL_BOT, bot);
	endtask

	task automatic queue_pixels(input int n, input bit banded);
		int base;
		base = $urandom_range(0, 248);
		for (int i = 0; i < n; i++) begin
			if (banded) pixel_queue.push_back(PIXEL_W'(base + $urandom_range(0, 7)));
			else pixel_queue.push_back(PIXEL_W'($urandom_range(0, 255)));
		end
	endtask

	// no word in flight, then a pause for words that produce no output
	task automatic wait_idle();
		while (pixel_queue.size() != 0 || s_tvalid || expected_words.size() != 0)
			@(posedge clk);
		repeat (FLUSH_CYCLES) @(posedge clk);
	endtask

	initial begin
		int                w, h, rem, n, sent, seg;
		logic [KROW_W-1:0] rows [3];
		logic [KROW_W-1:0] extremes [4];
		extremes = '{24'h7F7F7F, 24'h808080, 24'hFFFFFF, 24'h000000};
		for (int i = 0; i < LINE_DEPTH; i++) line_hist[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < NUM_REGS; i++) reg_readback(reg_idx_t'(i));

		// undersized geometry, largest coefficients: clamps high
		write_kernel(pack_row(127, 127, 127), pack_row(127, 127, 127), pack_row(127, 127, 127));
		reg_write(REG_FRAME_W, 0);
		reg_write(REG_FRAME_H, 1);
		pixel_queue = {8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255};
		wait_idle();

		// most negative coefficients: clamps low
		write_kernel(pack_row(-128, -128, -128), pack_row(-128, -128, -128),
			pack_row(-128, -128, -128));
		reg_write(REG_FRAME_W, 2);
		reg_write(REG_FRAME_H, 2);
		pixel_queue = {8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd200};
		wait_idle();

		// horizontal gradient, in range
		write_kernel(pack_row(-1, 0, 1), pack_row(-2, 0, 2), pack_row(-1, 0, 1));
		reg_write(REG_FRAME_W, 3);
		reg_write(REG_FRAME_H, 3);
		pixel_queue = {8'd10, 8'd99, 8'd60, 8'd10, 8'd0, 8'd60, 8'd10, 8'd255, 8'd60};
		wait_idle();

		sent = 0;
		seg = 0;
		while (sent < RANDOM_PIXELS) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			if (seg == 0 || $urandom_range(0, 1)) begin
				case ($urandom_range(0, 5))
					0: begin
						for (int i = 0; i < 3; i++) rows[i] = KROW_W'($urandom);
					end
					1: begin
						rows = '{pack_row(-1, 0, 1), pack_row(-2, 0, 2), pack_row(-1, 0, 1)};
					end
					2: begin
						rows = '{pack_row(-1, -2, -1), pack_row(0, 0, 0), pack_row(1, 2, 1)};
					end
					3: begin
						for (int i = 0; i < 3; i++)
							rows[i] = pack_row($urandom_range(0, 4) - 2, $urandom_range(0, 4) - 2,
								$urandom_range(0, 4) - 2);
					end
					4: begin
						for (int i = 0; i < 3; i++) rows[i] = extremes[$urandom_range(0, 3)];
					end
					default: begin
						rows = '{pack_row(0, 0, 0), pack_row(0, 1, 0), pack_row(0, 0, 0)};
					end
				endcase
				write_kernel(rows[0], rows[1], rows[2]);
			end
			// geometry changes may land mid-frame; counters carry over
			if (seg == 0 || $urandom_range(0, 1)) begin
				case ($urandom_range(0, 9))
					0, 1: w = $urandom_range(0, 2);
					2: w = $urandom_range(11, 64);
					3: w = $urandom_range(2040, 4095);
					default: w = $urandom_range(3, 10);
				endcase
				// mid-frame the width only grows over columns already written
				if ((col_pos != 0 || row_pos != 0) && w > cols_written) w = cols_written;
				reg_write(REG_FRAME_W, w);
			end
			if (seg == 0 || $urandom_range(0, 1)) begin
				case ($urandom_range(0, 9))
					0: h = $urandom_range(0, 2);
					1: h = 65535;
					2: h = $urandom_range(0, 65535);
					3, 4: h = $urandom_range(9, 20);
					default: h = $urandom_range(3, 8);
				endcase
				if (seg == 0) h = 65535;
				reg_write(REG_FRAME_H, h);
			end
			// words left in the frame from the current raster position
			w = active_width();
			h = active_height();
			rem = (col_pos >= w) ? 1 : w - col_pos;
			if (row_pos + 1 < h) rem += (h - 1 - row_pos) * w;
			n = (rem > 300 || $urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : rem;
			queue_pixels(n, $urandom_range(0, 2) == 0);
			sent += n;
			seg++;
			wait_idle();
		end

		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#60000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
